### hdl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// shared types and constants of the priority queue with aging
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int ID_BITS_DEF = 10;
  localparam int PRI_W       = 8;
  localparam logic [PRI_W-1:0] MAX_PRI_RESET = 8'd255;
  localparam logic [PRI_W-1:0] PRI_FLOOR     = 8'd1;

  // operation carried in s_tuser
  typedef enum logic {
    CMD_INSERT   = 1'b0,
    CMD_RETRIEVE = 1'b1
  } pfa_cmd_t;

  // result code carried in m_tuser
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPRI = 2'd3
  } pfa_status_t;

  // register indexes of the configuration port
  typedef enum logic {
    REG_PRI_LIMIT = 1'b0,
    REG_UNUSED    = 1'b1
  } pfa_reg_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             ins;
    logic             ret;
    logic [PRI_W-1:0] pri;
  } pfa_ctrl_t;

endpackage

### hdl/priority_fifo_with_aging_unit.sv
// ----------------------------------------------------------------------------
// priority_fifo_with_aging_unit
// bounded priority queue with aging, built as a sorted chain of cells
// ----------------------------------------------------------------------------
// usage
//   s_* takes one command transaction: s_tuser is the operation (insert or
//   retrieve), s_tdata carries the id and priority of an insert.
//   m_* returns exactly one result transaction per command: m_tuser is the
//   status code, m_tdata the removed id and the occupancy afterwards.
//   pri_limit is set over the apb-style port while the queue is idle.
// timing
//   every command is applied to the whole chain in the cycle it is accepted;
//   the result is registered and appears on m_* in the following cycle
//   one command per cycle is sustained while m_tready stays high: all cells
//   shift, insert and age in parallel, so the cell update sets the rate
// reset
//   rst empties the queue (cell valid bits and count cleared) and sets
//   pri_limit to 255; no clearing pass is needed
// back-pressure
//   while a result waits with m_tready low, s_tready drops and the chain
//   holds; the result register frees as soon as its transaction completes
// ----------------------------------------------------------------------------
module priority_fifo_with_aging_unit #(
  parameter int DEPTH   = pfa_pkg::DEPTH_DEF,
  parameter int ID_BITS = pfa_pkg::ID_BITS_DEF,
  localparam int CNT_W     = $clog2(DEPTH + 1),
  localparam int IN_W      = ID_BITS + pfa_pkg::PRI_W,
  localparam int IN_TD_W   = ((IN_W + 7) / 8) * 8,
  localparam int OUT_W     = ID_BITS + CNT_W,
  localparam int OUT_TD_W  = ((OUT_W + 7) / 8) * 8
) (
  input  logic                clk,
  input  logic                rst,
  // command stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [IN_TD_W-1:0]  s_tdata,   // entry_id, entry_priority, zero pad
  input  logic                s_tuser,   // cmd
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OUT_TD_W-1:0] m_tdata,   // out_id, occupancy, zero pad
  output logic [1:0]          m_tuser,   // status
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // unpacked command fields
  pfa_pkg::pfa_cmd_t          cmd;
  logic [ID_BITS-1:0]         entry_id;
  logic [pfa_pkg::PRI_W-1:0]  entry_priority;
  logic [pfa_pkg::PRI_W-1:0]  pri_limit;

  logic                       accept;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;
  pfa_pkg::pfa_status_t       status_next;
  pfa_pkg::pfa_ctrl_t         ctrl;

  // result register
  logic [ID_BITS-1:0]         out_id;
  logic [CNT_W-1:0]           occupancy;
  pfa_pkg::pfa_status_t       status;
  logic [ID_BITS-1:0]         out_id_next;

  // chain wiring
  logic [DEPTH-1:0]           cell_valid;
  logic [ID_BITS-1:0]         cell_id  [DEPTH];
  logic [pfa_pkg::PRI_W-1:0]  cell_pri [DEPTH];
  logic [DEPTH-1:0]           cell_keep;

  assign cmd            = pfa_pkg::pfa_cmd_t'(s_tuser);
  assign entry_id       = s_tdata[ID_BITS-1:0];
  assign entry_priority = s_tdata[IN_W-1:ID_BITS];

  // output register parts the two sides
  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  pfa_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .pri_limit (pri_limit)
  );

  // decide the operation; rejected commands leave the chain untouched
  always_comb begin
    status_next = pfa_pkg::ST_OK;
    count_next  = count;
    out_id_next = '0;
    ctrl.ins    = 1'b0;
    ctrl.ret    = 1'b0;
    ctrl.pri    = entry_priority;
    case (cmd)
      pfa_pkg::CMD_INSERT: begin
        // bad priority is checked before full
        if (entry_priority == '0 || entry_priority > pri_limit) begin
          status_next = pfa_pkg::ST_BADPRI;
        end else if (count == CNT_W'(DEPTH)) begin
          status_next = pfa_pkg::ST_FULL;
        end else begin
          ctrl.ins   = accept;
          count_next = count + CNT_W'(1);
        end
      end
      pfa_pkg::CMD_RETRIEVE: begin
        if (count == '0) begin
          status_next = pfa_pkg::ST_EMPTY;
        end else begin
          ctrl.ret    = accept;
          count_next  = count - CNT_W'(1);
          out_id_next = cell_id[0];
        end
      end
      default: begin
        status_next = pfa_pkg::ST_OK;
      end
    endcase
  end

  // the sorted chain, head at cell 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      prev_valid;
    logic [ID_BITS-1:0]        prev_id;
    logic [pfa_pkg::PRI_W-1:0] prev_pri;
    logic                      prev_keep;
    logic                      next_valid;
    logic [ID_BITS-1:0]        next_id;
    logic [pfa_pkg::PRI_W-1:0] next_pri;

    if (i == 0) begin : g_head
      // head cell takes the new entry whenever it does not keep its own
      assign prev_valid = 1'b0;
      assign prev_id    = '0;
      assign prev_pri   = '0;
      assign prev_keep  = 1'b1;
    end else begin : g_body
      assign prev_valid = cell_valid[i-1];
      assign prev_id    = cell_id[i-1];
      assign prev_pri   = cell_pri[i-1];
      assign prev_keep  = cell_keep[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_valid = 1'b0;
      assign next_id    = '0;
      assign next_pri   = '0;
    end else begin : g_inner
      assign next_valid = cell_valid[i+1];
      assign next_id    = cell_id[i+1];
      assign next_pri   = cell_pri[i+1];
    end

    pfa_cell #(
      .ID_BITS (ID_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_id     (entry_id),
      .prev_valid (prev_valid),
      .prev_id    (prev_id),
      .prev_pri   (prev_pri),
      .prev_keep  (prev_keep),
      .next_valid (next_valid),
      .next_id    (next_id),
      .next_pri   (next_pri),
      .valid      (cell_valid[i]),
      .id         (cell_id[i]),
      .pri        (cell_pri[i]),
      .keep       (cell_keep[i])
    );
  end

  // occupancy counter and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (accept) begin
      out_id    <= out_id_next;
      occupancy <= count_next;
      status    <= status_next;
    end
  end

  assign m_tdata = OUT_TD_W'({occupancy, out_id});
  assign m_tuser = status;

`ifndef SYNTHESIS
  // valid cells always form a prefix as long as the count
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    $countones(cell_valid) == 32'(count) && (cell_valid & (cell_valid + 1'b1)) == '0)
    else $error("cell valid bits disagree with occupancy count");

  // a rejected command leaves the count unchanged
  a_reject_holds: assert property (@(posedge clk) disable iff (rst)
    accept && status_next != pfa_pkg::ST_OK |=> count == $past(count))
    else $error("rejected transaction changed the queue");

  // only a successful retrieve reports an id
  a_id_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && status != pfa_pkg::ST_OK |-> out_id == '0)
    else $error("non-zero id on a rejected transaction");

  // head and second cell stay in order
  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    cell_valid[1] |-> cell_pri[0] <= cell_pri[1])
    else $error("chain head out of priority order");
`endif

endmodule

### hdl/pfa_cell.sv
// ----------------------------------------------------------------------------
// pfa_cell
// one slot of the sorted chain: holds an entry, shifts, inserts and ages
// ----------------------------------------------------------------------------
module pfa_cell #(
  parameter int ID_BITS = pfa_pkg::ID_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  pfa_pkg::pfa_ctrl_t       ctrl,
  input  logic [ID_BITS-1:0]       new_id,
  // neighbour towards the head
  input  logic                     prev_valid,
  input  logic [ID_BITS-1:0]       prev_id,
  input  logic [pfa_pkg::PRI_W-1:0] prev_pri,
  input  logic                     prev_keep,
  // neighbour towards the tail
  input  logic                     next_valid,
  input  logic [ID_BITS-1:0]       next_id,
  input  logic [pfa_pkg::PRI_W-1:0] next_pri,
  // own contents
  output logic                     valid,
  output logic [ID_BITS-1:0]       id,
  output logic [pfa_pkg::PRI_W-1:0] pri,
  output logic                     keep
);

  logic                      valid_next;
  logic [ID_BITS-1:0]        id_next;
  logic [pfa_pkg::PRI_W-1:0] pri_next;

  // entry stays put on insert when it is served no later than the new one
  assign keep = valid && (pri <= ctrl.pri);

  always_comb begin
    valid_next = valid;
    id_next    = id;
    pri_next   = pri;
    if (ctrl.ins && !keep) begin
      if (prev_keep) begin
        valid_next = 1'b1;
        id_next    = new_id;
        pri_next   = ctrl.pri;
      end else begin
        valid_next = prev_valid;
        id_next    = prev_id;
        pri_next   = prev_pri;
      end
    end else if (ctrl.ret) begin
      // pull towards the head and age by one, floor of one
      valid_next = next_valid;
      id_next    = next_id;
      pri_next   = (next_pri > pfa_pkg::PRI_FLOOR) ? next_pri - pfa_pkg::PRI_FLOOR : next_pri;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    id  <= id_next;
    pri <= pri_next;
  end

endmodule

### hdl/pfa_cfg.sv
// ----------------------------------------------------------------------------
// pfa_cfg
// configuration register file behind the apb-style port
// ----------------------------------------------------------------------------
module pfa_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [pfa_pkg::PRI_W-1:0] pri_limit
);

  pfa_pkg::pfa_reg_t reg_sel;
  logic              wr_en;

  assign reg_sel = pfa_pkg::pfa_reg_t'(paddr[2]);
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pri_limit <= pfa_pkg::MAX_PRI_RESET;
    end else if (wr_en && reg_sel == pfa_pkg::REG_PRI_LIMIT) begin
      pri_limit <= pwdata[pfa_pkg::PRI_W-1:0];
    end
  end

  always_comb begin
    case (reg_sel)
      pfa_pkg::REG_PRI_LIMIT: prdata = 32'(pri_limit);
      default:                prdata = 32'd0;
    endcase
  end

endmodule
